// ===== design/tis_pkg.sv =====
package tis_pkg;

    localparam int FUNC_W     = 2;
    localparam int OBJ_ID_W   = 16;
    localparam int POS_W      = 16;
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int SLOTS_W    = 5;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MOVE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEND_ENABLE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'd1;

    localparam logic [SLOTS_W-1:0] SLOTS_IN_USE_RESET = 5'd10;

    // One classified item waiting for the table sequencer.
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [OBJ_ID_W-1:0] key;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic [KIND_W-1:0]   event_kind;
        logic [SLOT_W-1:0]   slot_index;
        logic [OBJ_ID_W-1:0] object_id_out;
        logic [POS_W-1:0]    pos_x_out;
        logic [POS_W-1:0]    pos_y_out;
    } report_t;

endpackage

// ===== design/tis_ifs.sv =====
interface tis_evt_if import tis_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [OBJ_ID_W-1:0] object_id;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;

    modport source (output valid, func, object_id, pos_x, pos_y, input ready);
    modport sink (input valid, func, object_id, pos_x, pos_y, output ready);
endinterface

interface tis_rpt_if import tis_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   event_kind;
    logic [SLOT_W-1:0]   slot_index;
    logic [OBJ_ID_W-1:0] object_id_out;
    logic [POS_W-1:0]    pos_x_out;
    logic [POS_W-1:0]    pos_y_out;

    modport source (output valid, event_kind, slot_index, object_id_out, pos_x_out, pos_y_out,
                    input ready);
    modport sink (input valid, event_kind, slot_index, object_id_out, pos_x_out, pos_y_out,
                  output ready);
endinterface

// ===== design/tracked_id_slot_table.sv =====
// Channel  Role    Handshake      Payload
// evt      sink    valid/ready    func, object_id, pos_x, pos_y
// rpt      source  valid/ready    event_kind, slot_index, object_id_out, pos_x_out, pos_y_out
// cfg      write   cfg_we         cfg_index, cfg_data
//
// An add, delete, or move with reports on is handled in the table sequencer, which scans up to
// limit slots, where limit is slots_in_use saturated to MAX_SLOTS; the id memory is read one
// slot per cycle and a hit ends the scan early. Other items are dropped at the input.
// Reset clears every slot at once through per-slot valid bits; no clearing pass is needed.
// A two-item queue separates input from sequencer; the sequencer waits while a report is
// still held in the output register.
module tracked_id_slot_table
    import tis_pkg::*;
#(
    parameter int MAX_SLOTS = 16,
    parameter int ID_WIDTH  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    tis_evt_if.sink               evt,
    tis_rpt_if.source             rpt,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic               send_enable_reg;
    logic [SLOTS_W-1:0] slots_in_use_reg;
    q_stat_t            q_stat;
    logic               push;
    logic               pop;
    cmd_t               push_cmd;
    cmd_t               head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_enable_reg  <= 1'b0;
            slots_in_use_reg <= SLOTS_IN_USE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEND_ENABLE:  send_enable_reg  <= cfg_data[0];
                CFG_SLOTS_IN_USE: slots_in_use_reg <= cfg_data[SLOTS_W-1:0];
                default: ;
            endcase
        end
    end

    tis_front #(
        .ID_WIDTH (ID_WIDTH)
    ) u_front (
        .evt         (evt),
        .send_enable (send_enable_reg),
        .q_stat      (q_stat),
        .push        (push),
        .cmd         (push_cmd)
    );

    tis_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    tis_back #(
        .MAX_SLOTS (MAX_SLOTS),
        .ID_WIDTH  (ID_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .send_enable  (send_enable_reg),
        .slots_in_use (slots_in_use_reg),
        .q_stat       (q_stat),
        .head         (head),
        .pop          (pop),
        .rpt          (rpt)
    );

endmodule

// ===== design/tis_front.sv =====
module tis_front
    import tis_pkg::*;
#(
    parameter int ID_WIDTH = 16
)
(
    tis_evt_if.sink     evt,
    input  logic        send_enable,
    input  q_stat_t     q_stat,
    output logic        push,
    output cmd_t        cmd
);

    localparam logic [OBJ_ID_W-1:0] ID_MASK = (ID_WIDTH >= OBJ_ID_W) ? {OBJ_ID_W{1'b1}} :
        OBJ_ID_W'((32'd1 << ID_WIDTH) - 32'd1);

    logic accept;
    logic keep;

    assign evt.ready = !q_stat.full;
    assign accept    = evt.valid && evt.ready;

    // A move with reports off has no effect at all, and the unused code is ignored,
    // so neither reaches the table.
    always_comb
    begin
        case (evt.func)
            FUNC_ADD:    keep = 1'b1;
            FUNC_DELETE: keep = 1'b1;
            FUNC_MOVE:   keep = send_enable;
            default:     keep = 1'b0;
        endcase
    end

    assign push      = accept && keep;
    assign cmd.func  = evt.func;
    assign cmd.key   = evt.object_id & ID_MASK;
    assign cmd.pos_x = evt.pos_x;
    assign cmd.pos_y = evt.pos_y;

endmodule

// ===== design/tis_queue.sv =====
module tis_queue
    import tis_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t q_stat
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.empty = (cnt_reg == 2'd0);
    assign q_stat.full  = (cnt_reg == 2'd2);

endmodule

// ===== design/tis_back.sv =====
module tis_back
    import tis_pkg::*;
#(
    parameter int MAX_SLOTS = 16,
    parameter int ID_WIDTH  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               send_enable,
    input  logic [SLOTS_W-1:0] slots_in_use,
    input  q_stat_t            q_stat,
    input  cmd_t               head,
    output logic               pop,
    tis_rpt_if.source          rpt
);

    localparam int KW   = (ID_WIDTH < OBJ_ID_W) ? ID_WIDTH : OBJ_ID_W;
    localparam int AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int IDXW = $clog2(MAX_SLOTS + 1);
    localparam int LW   = (IDXW > SLOTS_W) ? IDXW : SLOTS_W;

    typedef enum logic {S_IDLE, S_SCAN} state_t;

    state_t                state_reg;
    cmd_t                  cmd_reg;
    logic [IDXW-1:0]       idx_reg;
    logic                  pend_reg;
    logic [AW-1:0]         rd_idx_reg;
    logic [KW-1:0]         rd_id_reg;
    logic [MAX_SLOTS-1:0]  valid_reg;
    logic                  rpt_valid_reg;
    report_t               rpt_reg;
    logic [KW-1:0]         id_mem [MAX_SLOTS];

    logic [LW-1:0] limit;
    logic          more;
    logic          slot_v;
    logic          hit;
    logic          mem_we;

    // Settings above the table size saturate to it.
    assign limit  = (LW'(slots_in_use) > LW'(MAX_SLOTS)) ? LW'(MAX_SLOTS) : LW'(slots_in_use);
    assign more   = LW'(idx_reg) < limit;
    assign slot_v = valid_reg[rd_idx_reg];

    // The compare stage looks at the slot read in the previous cycle: an add wants
    // a free slot, a lookup a valid slot holding the key.
    always_comb
    begin
        if (cmd_reg.func == FUNC_ADD)
            hit = pend_reg && !slot_v;
        else
            hit = pend_reg && slot_v && (rd_id_reg == KW'(cmd_reg.key));
    end

    assign pop    = (state_reg == S_IDLE) && !q_stat.empty && !rpt_valid_reg;
    assign mem_we = (state_reg == S_SCAN) && hit && (cmd_reg.func == FUNC_ADD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
            valid_reg     <= '0;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            if (rpt_valid_reg && rpt.ready)
                rpt_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    pend_reg <= 1'b0;
                    if (pop)
                    begin
                        cmd_reg   <= head;
                        idx_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (hit)
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                        if (cmd_reg.func == FUNC_ADD)
                            valid_reg[rd_idx_reg] <= 1'b1;
                        else if (cmd_reg.func == FUNC_DELETE)
                            valid_reg[rd_idx_reg] <= 1'b0;
                        if (send_enable)
                        begin
                            rpt_valid_reg         <= 1'b1;
                            rpt_reg.event_kind    <= cmd_reg.func;
                            rpt_reg.slot_index    <= SLOT_W'(rd_idx_reg);
                            rpt_reg.object_id_out <= cmd_reg.key;
                            rpt_reg.pos_x_out     <= cmd_reg.pos_x;
                            rpt_reg.pos_y_out     <= cmd_reg.pos_y;
                        end
                    end
                    else if (more)
                    begin
                        pend_reg   <= 1'b1;
                        rd_idx_reg <= idx_reg[AW-1:0];
                        idx_reg    <= idx_reg + IDXW'(1);
                    end
                    else
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            id_mem[rd_idx_reg] <= KW'(cmd_reg.key);
        rd_id_reg <= id_mem[idx_reg[AW-1:0]];
    end

    assign rpt.valid         = rpt_valid_reg;
    assign rpt.event_kind    = rpt_reg.event_kind;
    assign rpt.slot_index    = rpt_reg.slot_index;
    assign rpt.object_id_out = rpt_reg.object_id_out;
    assign rpt.pos_x_out     = rpt_reg.pos_x_out;
    assign rpt.pos_y_out     = rpt_reg.pos_y_out;

    a_rpt_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rpt_valid_reg) |-> $past(state_reg == S_SCAN) && $past(hit))
        else $error("report raised without a table hit");

    a_pop_output_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !rpt_valid_reg && !q_stat.empty)
        else $error("item taken while the report register is busy");

    a_hit_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && hit) |=> state_reg == S_IDLE && !pend_reg)
        else $error("scan continued after a hit");

endmodule
